### hdl/assert_macros.svh
// Assertion helpers shared by the RTL. Every macro samples on the rising edge
// of clk and is switched off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Invariant that holds at every edge out of reset.
`define ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

`else

`define ASSERT_IMPLIES(lbl, ante, cons, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)
`define ASSERT_ALWAYS(lbl, cond, msg)

`endif

`endif

### hdl/bmsirq_pkg.sv
package bmsirq_pkg;

    // Input beat.
    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] address;
        logic [7:0]  write_data;
    } item_t;

    // Result beat.
    typedef struct packed {
        logic [7:0]  prg_bank_8000;
        logic [4:0]  prg_bank_a000;
        logic [7:0]  prg_bank_c000;
        logic [1:0]  mirroring;
        logic [35:0] chr_banks_low;
        logic [35:0] chr_banks_high;
        logic        irq_line;
    } result_t;

    // Action codes.
    localparam logic [1:0] ACT_WRITE    = 2'd0;
    localparam logic [1:0] ACT_CPU_TICK = 2'd1;
    localparam logic [1:0] ACT_PPU_TICK = 2'd2;

    // Register pages, taken from address bits 15..12.
    localparam logic [3:0] PAGE_PRG_FIRST  = 4'h8;
    localparam logic [3:0] PAGE_MIRROR     = 4'h9;
    localparam logic [3:0] PAGE_PRG_SECOND = 4'hA;
    localparam logic [3:0] PAGE_CHR_FIRST  = 4'hB;
    localparam logic [3:0] PAGE_CHR_SECOND = 4'hC;
    localparam logic [3:0] PAGE_CHR_THIRD  = 4'hD;
    localparam logic [3:0] PAGE_CHR_FOURTH = 4'hE;
    localparam logic [3:0] PAGE_IRQ        = 4'hF;

    // Sub-register codes within the IRQ page.
    localparam logic [1:0] SUB_RELOAD_LOW  = 2'd0;
    localparam logic [1:0] SUB_CONTROL     = 2'd1;
    localparam logic [1:0] SUB_RELOAD_HIGH = 2'd2;
    localparam logic [1:0] SUB_ACK         = 2'd3;

    // IRQ control bit positions.
    localparam int IRQ_CTRL_A = 0;  // re-enable after acknowledge
    localparam int IRQ_CTRL_E = 1;  // enable
    localparam int IRQ_CTRL_M = 2;  // cycle mode

    // Board variants a..e.
    localparam int          NUM_VARIANTS = 5;
    localparam logic [2:0]  DEFAULT_VARIANT = 3'd0;

    // Address shift that brings the sub-register lines down to bits 1..0.
    localparam logic [2:0] SUB_SHIFT [NUM_VARIANTS] = '{3'd1, 3'd0, 3'd6, 3'd2, 3'd2};
    // Whether the two sub-register lines are crossed on the board.
    localparam logic       SUB_SWAP  [NUM_VARIANTS] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1};

    localparam logic [9:0] PRESCALE_PERIOD = 10'd341;
    localparam logic [9:0] PRESCALE_STEP   = 10'd2;
    localparam logic [7:0] FIXED_BANK      = 8'hFE;
    localparam logic [7:0] COUNT_TERMINAL  = 8'hFF;

endpackage

### hdl/bank_mapper_with_scanline_irq.sv
// Channel   Direction  Signals                              Payload type
// item      in         item_valid, item_ready, item         bmsirq_pkg::item_t
// result    out        result_valid, result_ready, result   bmsirq_pkg::result_t
// config    in         cfg_wr_en, cfg_wr_data               3-bit board variant
//
// Every accepted beat updates the mapper state at the accepting edge, and its
// result beat is valid from the next cycle on. One beat per clock is sustained while
// result_ready is high; the only limit is the single output register.
// item_ready is high whenever the output register is empty or is being drained in
// the same cycle, so a stalled result blocks new input only while it waits.
// rst_n clears all mapper and IRQ state asynchronously and empties the output.

`include "assert_macros.svh"

module bank_mapper_with_scanline_irq (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [2:0]          cfg_wr_data,
    input  logic                item_valid,
    output logic                item_ready,
    input  bmsirq_pkg::item_t   item,
    output logic                result_valid,
    input  logic                result_ready,
    output bmsirq_pkg::result_t result
);

    // Configuration.
    logic [2:0] board_variant_reg;

    // Mapper state and its next values.
    logic [4:0] prg_bank_first_reg,  prg_bank_first_next;
    logic [4:0] prg_bank_second_reg, prg_bank_second_next;
    logic       prg_swap_reg,        prg_swap_next;
    logic [1:0] mirror_mode_reg,     mirror_mode_next;
    logic [8:0] chr_bank_reg  [8];
    logic [8:0] chr_bank_next [8];
    logic [2:0] irq_ctrl_reg,        irq_ctrl_next;
    logic [7:0] irq_reload_reg,      irq_reload_next;
    logic [7:0] irq_count_reg,       irq_count_next;
    logic [9:0] irq_prescale_reg,    irq_prescale_next;
    logic       irq_pending_reg,     irq_pending_next;

    // Output register.
    logic                result_valid_reg, result_valid_next;
    bmsirq_pkg::result_t result_reg,       result_next;

    // Decode of the accepted beat.
    logic       accept;
    logic [2:0] variant_idx;
    logic [1:0] sub_raw;
    logic [1:0] sub_sel;
    logic [3:0] page;
    logic [4:0] reg_data;
    logic [2:0] chr_idx;
    logic [3:0] chr_page_offset;
    logic       count_clock;
    logic       pending_clear;

    assign item_ready   = !result_valid_reg || result_ready;
    assign accept       = item_valid && item_ready;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // An out-of-range variant behaves as variant a.
    assign variant_idx = (board_variant_reg < 3'(bmsirq_pkg::NUM_VARIANTS)) ?
                         board_variant_reg : bmsirq_pkg::DEFAULT_VARIANT;
    assign sub_raw     = 2'(item.address >> bmsirq_pkg::SUB_SHIFT[variant_idx]);
    assign sub_sel     = bmsirq_pkg::SUB_SWAP[variant_idx] ? {sub_raw[0], sub_raw[1]}
                                                           : sub_raw;
    assign page            = item.address[15:12];
    assign reg_data        = item.write_data[4:0];
    assign chr_page_offset = page - bmsirq_pkg::PAGE_CHR_FIRST;
    assign chr_idx         = {chr_page_offset[1:0], sub_sel[0]};

    // Next-state logic for one beat. Register writes and ticks never coincide,
    // so the counter is clocked at most once per beat.
    always_comb
    begin
        prg_bank_first_next  = prg_bank_first_reg;
        prg_bank_second_next = prg_bank_second_reg;
        prg_swap_next        = prg_swap_reg;
        mirror_mode_next     = mirror_mode_reg;
        chr_bank_next        = chr_bank_reg;
        irq_ctrl_next        = irq_ctrl_reg;
        irq_reload_next      = irq_reload_reg;
        irq_count_next       = irq_count_reg;
        irq_prescale_next    = irq_prescale_reg;
        irq_pending_next     = irq_pending_reg;
        count_clock          = 1'b0;
        pending_clear        = 1'b0;

        if (accept)
        begin
            case (item.action)
                bmsirq_pkg::ACT_WRITE:
                begin
                    // Writes below 0x8000 fall outside the mapper.
                    if (item.address[15])
                    begin
                        case (page)
                            bmsirq_pkg::PAGE_PRG_FIRST:
                                prg_bank_first_next = reg_data;
                            bmsirq_pkg::PAGE_MIRROR:
                            begin
                                if (!sub_sel[1])
                                    mirror_mode_next = reg_data[1:0];
                                else
                                    prg_swap_next = reg_data[1];
                            end
                            bmsirq_pkg::PAGE_PRG_SECOND:
                                prg_bank_second_next = reg_data;
                            bmsirq_pkg::PAGE_CHR_FIRST,
                            bmsirq_pkg::PAGE_CHR_SECOND,
                            bmsirq_pkg::PAGE_CHR_THIRD,
                            bmsirq_pkg::PAGE_CHR_FOURTH:
                            begin
                                // The upper line picks the high five bits or the
                                // low nibble of the bank.
                                if (sub_sel[1])
                                    chr_bank_next[chr_idx][8:4] = reg_data;
                                else
                                    chr_bank_next[chr_idx][3:0] = reg_data[3:0];
                            end
                            bmsirq_pkg::PAGE_IRQ:
                            begin
                                case (sub_sel)
                                    bmsirq_pkg::SUB_RELOAD_LOW:
                                        irq_reload_next[3:0] = reg_data[3:0];
                                    bmsirq_pkg::SUB_RELOAD_HIGH:
                                        irq_reload_next[7:4] = reg_data[3:0];
                                    bmsirq_pkg::SUB_CONTROL:
                                    begin
                                        irq_ctrl_next    = reg_data[2:0];
                                        irq_pending_next = 1'b0;
                                        pending_clear    = 1'b1;
                                        if (reg_data[bmsirq_pkg::IRQ_CTRL_E])
                                        begin
                                            irq_count_next    = irq_reload_reg;
                                            irq_prescale_next =
                                                bmsirq_pkg::PRESCALE_PERIOD;
                                        end
                                    end
                                    bmsirq_pkg::SUB_ACK:
                                    begin
                                        irq_pending_next = 1'b0;
                                        pending_clear    = 1'b1;
                                        irq_ctrl_next[bmsirq_pkg::IRQ_CTRL_E] =
                                            irq_ctrl_reg[bmsirq_pkg::IRQ_CTRL_A];
                                    end
                                    default:
                                    begin
                                    end
                                endcase
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                bmsirq_pkg::ACT_CPU_TICK:
                begin
                    if (irq_ctrl_reg[bmsirq_pkg::IRQ_CTRL_E] &&
                        irq_ctrl_reg[bmsirq_pkg::IRQ_CTRL_M])
                        count_clock = 1'b1;
                end
                bmsirq_pkg::ACT_PPU_TICK:
                begin
                    // Scanline mode: the prescaler drops by two per PPU tick and
                    // wraps by adding one scanline length of 341.
                    if (irq_ctrl_reg[bmsirq_pkg::IRQ_CTRL_E] &&
                        !irq_ctrl_reg[bmsirq_pkg::IRQ_CTRL_M])
                    begin
                        if (irq_prescale_reg <= bmsirq_pkg::PRESCALE_STEP)
                        begin
                            irq_prescale_next = irq_prescale_reg +
                                (bmsirq_pkg::PRESCALE_PERIOD - bmsirq_pkg::PRESCALE_STEP);
                            count_clock = 1'b1;
                        end
                        else
                        begin
                            irq_prescale_next = irq_prescale_reg - bmsirq_pkg::PRESCALE_STEP;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end

        // The counter reloads and raises the interrupt when it clocks past 0xFF.
        if (count_clock)
        begin
            if (irq_count_reg == bmsirq_pkg::COUNT_TERMINAL)
            begin
                irq_count_next   = irq_reload_reg;
                irq_pending_next = 1'b1;
            end
            else
            begin
                irq_count_next = irq_count_reg + 8'd1;
            end
        end
    end

    // The result reflects the state after the beat.
    always_comb
    begin
        result_next = result_reg;
        result_valid_next = result_valid_reg && !result_ready;
        if (accept)
        begin
            result_valid_next = 1'b1;
            result_next.prg_bank_8000 = prg_swap_next ? bmsirq_pkg::FIXED_BANK
                                                      : {3'b000, prg_bank_first_next};
            result_next.prg_bank_a000 = prg_bank_second_next;
            result_next.prg_bank_c000 = prg_swap_next ? {3'b000, prg_bank_first_next}
                                                      : bmsirq_pkg::FIXED_BANK;
            result_next.mirroring     = mirror_mode_next;
            for (int i = 0; i < 4; i++)
            begin
                result_next.chr_banks_low[9*i +: 9]  = chr_bank_next[i];
                result_next.chr_banks_high[9*i +: 9] = chr_bank_next[i + 4];
            end
            result_next.irq_line = irq_pending_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            board_variant_reg   <= bmsirq_pkg::DEFAULT_VARIANT;
            prg_bank_first_reg  <= '0;
            prg_bank_second_reg <= '0;
            prg_swap_reg        <= 1'b0;
            mirror_mode_reg     <= '0;
            for (int i = 0; i < 8; i++)
                chr_bank_reg[i] <= '0;
            irq_ctrl_reg        <= '0;
            irq_reload_reg      <= '0;
            irq_count_reg       <= '0;
            irq_prescale_reg    <= '0;
            irq_pending_reg     <= 1'b0;
            result_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                board_variant_reg <= cfg_wr_data;
            prg_bank_first_reg  <= prg_bank_first_next;
            prg_bank_second_reg <= prg_bank_second_next;
            prg_swap_reg        <= prg_swap_next;
            mirror_mode_reg     <= mirror_mode_next;
            chr_bank_reg        <= chr_bank_next;
            irq_ctrl_reg        <= irq_ctrl_next;
            irq_reload_reg      <= irq_reload_next;
            irq_count_reg       <= irq_count_next;
            irq_prescale_reg    <= irq_prescale_next;
            irq_pending_reg     <= irq_pending_next;
            result_valid_reg    <= result_valid_next;
        end
    end

    // Result payload carries no reset.
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    `ASSERT_NEXT(a_accept_fills_output, accept, result_valid_reg, "accepted beat produced no result")
    `ASSERT_IMPLIES(a_irq_matches_state, result_valid_reg && accept, result_next.irq_line == irq_pending_next, "irq line disagrees with pending state")
    `ASSERT_ALWAYS(a_prescale_in_range, irq_prescale_reg <= bmsirq_pkg::PRESCALE_PERIOD, "prescaler beyond one scanline")
    `ASSERT_NEXT(a_ack_clears_pending, pending_clear, !irq_pending_reg, "control or acknowledge write left irq pending")
    `ASSERT_IMPLIES(a_one_fixed_bank, result_valid_reg, (result_reg.prg_bank_8000 == bmsirq_pkg::FIXED_BANK) || (result_reg.prg_bank_c000 == bmsirq_pkg::FIXED_BANK), "neither PRG window shows the fixed bank")

endmodule
